/* sv/bgi_pkg.sv */
// ----------------------------------------------------------------------------
// bgi_pkg: shared types and constants for the bitsliced gate interpreter
// Opcodes, register indexes, sequencer states and the command record that
// travels from the front end through the queue to the execute stage.
// ----------------------------------------------------------------------------
package bgi_pkg;

  localparam int BGI_MEM_WORDS    = 4096;
  localparam int BGI_QUEUE_DEPTH  = 2;
  localparam int BGI_ADDR_FIELD_W = 12;
  localparam int BGI_LANE_W       = 6;
  localparam int BGI_WORD_W       = 64;
  localparam int BGI_LANES_W      = 7;
  localparam int BGI_CFG_IDX_W    = 1;

  // lane j lives at word bit j ^ 7 (low three bits inverted, so lane order in each byte is reversed)
  localparam logic [BGI_LANE_W-1:0] BGI_LANE_SWAP = 6'd7;

  typedef enum logic [2:0] {
    OP_XOR     = 3'd0,
    OP_AND     = 3'd1,
    OP_OR      = 3'd2,
    OP_NOT     = 3'd3,
    OP_RANDOM  = 3'd4,
    OP_LOAD    = 3'd5,
    OP_READ    = 3'd6,
    OP_INVALID = 3'd7
  } bgi_op_t;

  typedef enum logic [BGI_CFG_IDX_W-1:0] {
    CFG_BATCH_LANES   = 1'b0,
    CFG_RANDOM_ENABLE = 1'b1
  } bgi_cfg_idx_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } bgi_state_t;

  // classified command, addresses travel beside it
  typedef struct packed {
    bgi_op_t                 op;
    logic [BGI_LANE_W-1:0]   pos;
    logic                    bit_value;
    logic [BGI_WORD_W-1:0]   random_word;
  } bgi_cmd_t;

  // configuration seen by the execute stage
  typedef struct packed {
    logic [BGI_WORD_W-1:0] not_mask;
    logic                  random_enable;
  } bgi_cfg_t;

endpackage

/* sv/bgi_in_if.sv */
// ----------------------------------------------------------------------------
// bgi_in_if: gate item channel
// Valid/ready channel carrying one gate item per accepted transfer.
// ----------------------------------------------------------------------------
interface bgi_in_if import bgi_pkg::*;;
  logic                        valid;
  logic                        ready;
  logic [2:0]                  operation;
  logic [BGI_ADDR_FIELD_W-1:0] dest_address;
  logic [BGI_ADDR_FIELD_W-1:0] source_a;
  logic [BGI_ADDR_FIELD_W-1:0] source_b;
  logic [BGI_LANE_W-1:0]       lane;
  logic                        bit_value;
  logic [BGI_WORD_W-1:0]       random_word;

  modport source (
    output valid, operation, dest_address, source_a, source_b, lane, bit_value,
           random_word,
    input  ready
  );
  modport sink (
    input  valid, operation, dest_address, source_a, source_b, lane, bit_value,
           random_word,
    output ready
  );
endinterface

/* sv/bgi_out_if.sv */
// ----------------------------------------------------------------------------
// bgi_out_if: result channel
// Valid/ready channel carrying one result item per gate item.
// ----------------------------------------------------------------------------
interface bgi_out_if import bgi_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [BGI_WORD_W-1:0] result_word;
  logic                  status;

  modport source (
    output valid, result_word, status,
    input  ready
  );
  modport sink (
    input  valid, result_word, status,
    output ready
  );
endinterface

/* sv/bgi_front.sv */
// ----------------------------------------------------------------------------
// bgi_front: item intake and classification
// Registers each item, decodes the opcode, picks the word that feeds operand
// A, computes the lane bit position and folds the addresses into the memory.
// ----------------------------------------------------------------------------
module bgi_front import bgi_pkg::*; #(
  parameter int MEM_WORDS = BGI_MEM_WORDS,
  parameter int ADDR_W    = $clog2(MEM_WORDS)
) (
  input  logic              clk,
  input  logic              rst_n,
  bgi_in_if.sink            in_ch,
  input  logic              q_ready,
  output logic              q_push,
  output logic [ADDR_W-1:0] addr_d,
  output logic [ADDR_W-1:0] addr_a,
  output logic [ADDR_W-1:0] addr_b,
  output bgi_cmd_t          cmd
);

  // address fold by reciprocal: q is floor(x / MEM_WORDS) or one less
  localparam int RECIP_SH = 24;
  localparam logic [RECIP_SH-1:0] RECIP = RECIP_SH'((64'd1 << RECIP_SH) / MEM_WORDS);
  localparam int PROD_W = BGI_ADDR_FIELD_W + RECIP_SH;
  localparam int EXT_W  = (ADDR_W > BGI_ADDR_FIELD_W) ? ADDR_W : BGI_ADDR_FIELD_W;

  typedef logic [BGI_ADDR_FIELD_W-1:0] afield_t;

  function automatic afield_t quot_est(input afield_t x);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(x) * PROD_W'(RECIP);
    return prod[PROD_W-1 -: BGI_ADDR_FIELD_W];
  endfunction

  function automatic logic [ADDR_W-1:0] fold(input afield_t x, input afield_t q);
    afield_t          r;
    logic [EXT_W-1:0] rx;
    r = x - BGI_ADDR_FIELD_W'(q * MEM_WORDS);
    if (32'(r) >= MEM_WORDS) begin
      r = r - BGI_ADDR_FIELD_W'(MEM_WORDS);
    end
    rx = EXT_W'(r);
    return rx[ADDR_W-1:0];
  endfunction

  logic     s1_valid_r, s1_valid_nxt;
  logic     accept;
  afield_t  sel_a;
  afield_t  xd_r, xa_r, xb_r;
  afield_t  qd_r, qa_r, qb_r;
  bgi_cmd_t cmd_r;

  // stage register frees up whenever the queue takes its item
  assign in_ch.ready  = !s1_valid_r || q_ready;
  assign accept       = in_ch.valid && in_ch.ready;
  assign s1_valid_nxt = accept || (s1_valid_r && !q_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // a bit load reads back its own destination word
  assign sel_a = (bgi_op_t'(in_ch.operation) == OP_LOAD) ? in_ch.dest_address
                                                          : in_ch.source_a;

  // classification and quotient estimate
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r.op          <= bgi_op_t'(in_ch.operation);
      cmd_r.pos         <= in_ch.lane ^ BGI_LANE_SWAP;
      cmd_r.bit_value   <= in_ch.bit_value;
      cmd_r.random_word <= in_ch.random_word;
      xd_r              <= in_ch.dest_address;
      xa_r              <= sel_a;
      xb_r              <= in_ch.source_b;
      qd_r              <= quot_est(in_ch.dest_address);
      qa_r              <= quot_est(sel_a);
      qb_r              <= quot_est(in_ch.source_b);
    end
  end

  // remainder and correction on the way into the queue
  assign q_push = s1_valid_r && q_ready;
  assign addr_d = fold(xd_r, qd_r);
  assign addr_a = fold(xa_r, qa_r);
  assign addr_b = fold(xb_r, qb_r);
  assign cmd    = cmd_r;

endmodule

/* sv/bgi_fifo.sv */
// ----------------------------------------------------------------------------
// bgi_fifo: command queue
// Small register queue between intake and execute so each side stalls alone.
// ----------------------------------------------------------------------------
module bgi_fifo import bgi_pkg::*; #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = BGI_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              push_ready,
  output logic              pop_valid,
  output logic [DATA_W-1:0] pop_data,
  input  logic              pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  logic [DATA_W-1:0] entry_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = entry_r[rd_ptr_r];

  // pointer wrap and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> count_r != CNT_W'(DEPTH))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("queue pop while empty");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == CNT_W'($past(count_r) + 1'b1))
    else $error("queue count did not follow a push");

endmodule

/* sv/bgi_back.sv */
// ----------------------------------------------------------------------------
// bgi_back: word memory and gate execution
// Reads both operands from the word memory, evaluates the gate, writes back
// the destination (not on READ/INVALID), holds the result in the output register.
// ----------------------------------------------------------------------------
module bgi_back import bgi_pkg::*; #(
  parameter int MEM_WORDS = BGI_MEM_WORDS,
  parameter int ADDR_W    = $clog2(MEM_WORDS)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  logic [ADDR_W-1:0] addr_d,
  input  logic [ADDR_W-1:0] addr_a,
  input  logic [ADDR_W-1:0] addr_b,
  input  bgi_cmd_t          cmd,
  output logic              q_pop,
  input  bgi_cfg_t          cfg,
  bgi_out_if.source         out_ch
);

  bgi_state_t            state_r, state_nxt;
  logic                  out_fire;
  logic                  exec_done;
  logic                  mem_we;

  logic [BGI_WORD_W-1:0] mem [MEM_WORDS];
  logic [BGI_WORD_W-1:0] rd_a_r, rd_b_r;
  bgi_cmd_t              cmd_r;
  logic [ADDR_W-1:0]     wr_addr_r;

  logic [BGI_WORD_W-1:0] w_calc;
  logic                  status_calc;
  logic                  we_calc;

  logic                  out_valid_r;
  logic [BGI_WORD_W-1:0] out_word_r;
  logic                  out_status_r;

  assign out_fire = !out_valid_r || out_ch.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (q_valid)  state_nxt = ST_EXEC;
      ST_EXEC: if (out_fire) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    q_pop     = 1'b0;
    exec_done = 1'b0;
    unique case (state_r)
      ST_IDLE: q_pop     = q_valid;
      ST_EXEC: exec_done = out_fire;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // item held for the execute state
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r     <= cmd;
      wr_addr_r <= addr_d;
    end
  end

  // word memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr_r] <= w_calc;
    end
    if (q_pop) begin
      rd_a_r <= mem[addr_a];
      rd_b_r <= mem[addr_b];
    end
  end

  // gate evaluation
  always_comb begin
    w_calc      = '0;
    status_calc = 1'b0;
    we_calc     = 1'b1;
    unique case (cmd_r.op)
      OP_XOR:    w_calc = rd_a_r ^ rd_b_r;
      OP_AND:    w_calc = rd_a_r & rd_b_r;
      OP_OR:     w_calc = rd_a_r | rd_b_r;
      OP_NOT:    w_calc = cfg.not_mask ^ rd_a_r;
      OP_RANDOM: w_calc = cfg.random_enable ? cmd_r.random_word : '0;
      OP_LOAD: begin
        // lane 0 starts a fresh word
        w_calc = ((cmd_r.pos == BGI_LANE_SWAP) ? '0 : rd_a_r)
               | (BGI_WORD_W'(cmd_r.bit_value) << cmd_r.pos);
      end
      OP_READ: begin
        w_calc  = BGI_WORD_W'(rd_a_r[cmd_r.pos]);
        we_calc = 1'b0;
      end
      OP_INVALID: begin
        status_calc = 1'b1;
        we_calc     = 1'b0;
      end
      default: we_calc = 1'b0;
    endcase
  end

  assign mem_we = exec_done && we_calc;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_done) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_done) begin
      out_word_r   <= w_calc;
      out_status_r <= status_calc;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_word = out_word_r;
  assign out_ch.status      = out_status_r;

  a_pop_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> state_r == ST_EXEC)
    else $error("popped item did not reach execute");

  a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EXEC))
    else $error("result appeared without an execute cycle");

  a_no_write_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> cmd_r.op != OP_READ && cmd_r.op != OP_INVALID)
    else $error("memory written by a read or invalid item");

endmodule

/* sv/bitsliced_gate_interpreter.sv */
// ----------------------------------------------------------------------------
// Path: an accepted item passes the intake register, the command queue, the
// operand read registers and the output register. The sequencer pops a new
// item only after the last one is executed on the single-write-port memory.
// Reset: synchronous, active low; clears queue, sequencer and output valid,
// sets batch_lanes to 64 and random_enable to 1. Word memory is not cleared.
// ----------------------------------------------------------------------------
// bitsliced_gate_interpreter: top level
// Bitsliced Boolean gate interpreter over 64-bit words with a configuration
// write port, intake stage, command queue and execute stage.
// ----------------------------------------------------------------------------
module bitsliced_gate_interpreter import bgi_pkg::*; #(
  parameter int MEM_WORDS   = BGI_MEM_WORDS,
  parameter int QUEUE_DEPTH = BGI_QUEUE_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  bgi_in_if.sink                   in_ch,
  bgi_out_if.source                out_ch,
  input  logic                     cfg_we,
  input  logic [BGI_CFG_IDX_W-1:0] cfg_index,
  input  logic [BGI_LANES_W-1:0]   cfg_data
);

  localparam int ADDR_W = $clog2(MEM_WORDS);
  localparam int CMD_W  = $bits(bgi_cmd_t);
  localparam int Q_W    = 3 * ADDR_W + CMD_W;

  // mask of lanes 0 .. lanes-1 at their swapped bit positions
  function automatic logic [BGI_WORD_W-1:0] lane_mask(input logic [BGI_LANES_W-1:0] lanes);
    logic [BGI_WORD_W-1:0]  m;
    logic [BGI_LANES_W-1:0] j;
    m = '0;
    for (int p = 0; p < BGI_WORD_W; p++) begin
      j    = BGI_LANES_W'(p) ^ BGI_LANES_W'(BGI_LANE_SWAP);
      m[p] = (j < lanes);
    end
    return m;
  endfunction

  logic [BGI_WORD_W-1:0] not_mask_r;
  logic                  rnd_en_r;
  bgi_cfg_t              cfg;

  logic                  f_push;
  logic [ADDR_W-1:0]     f_addr_d, f_addr_a, f_addr_b;
  bgi_cmd_t              f_cmd;
  logic                  q_ready;
  logic                  q_valid;
  logic [Q_W-1:0]        q_data;
  logic                  q_pop;
  logic [ADDR_W-1:0]     b_addr_d, b_addr_a, b_addr_b;
  bgi_cmd_t              b_cmd;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      not_mask_r <= '1;
      rnd_en_r   <= 1'b1;
    end else if (cfg_we) begin
      unique case (bgi_cfg_idx_t'(cfg_index))
        CFG_BATCH_LANES:   not_mask_r <= lane_mask(cfg_data);
        CFG_RANDOM_ENABLE: rnd_en_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg.not_mask      = not_mask_r;
  assign cfg.random_enable = rnd_en_r;

  bgi_front #(
    .MEM_WORDS (MEM_WORDS),
    .ADDR_W    (ADDR_W)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_ready (q_ready),
    .q_push  (f_push),
    .addr_d  (f_addr_d),
    .addr_a  (f_addr_a),
    .addr_b  (f_addr_b),
    .cmd     (f_cmd)
  );

  bgi_fifo #(
    .DATA_W (Q_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (f_push),
    .push_data  ({f_addr_d, f_addr_a, f_addr_b, f_cmd}),
    .push_ready (q_ready),
    .pop_valid  (q_valid),
    .pop_data   (q_data),
    .pop        (q_pop)
  );

  assign {b_addr_d, b_addr_a, b_addr_b, b_cmd} = q_data;

  bgi_back #(
    .MEM_WORDS (MEM_WORDS),
    .ADDR_W    (ADDR_W)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .addr_d  (b_addr_d),
    .addr_a  (b_addr_a),
    .addr_b  (b_addr_b),
    .cmd     (b_cmd),
    .q_pop   (q_pop),
    .cfg     (cfg),
    .out_ch  (out_ch)
  );

endmodule

/* tb/sv/bitsliced_gate_interpreter_tb.sv */
// ----------------------------------------------------------------------------
// bitsliced_gate_interpreter_tb: self-checking testbench
// Drives gate items into the interpreter, predicts every result with a
// shadow copy of the word memory and lane configuration, and checks each
// result item in order. Covers directed corner cases, lane-count and random
// enable settings, random traffic under three idling mixes and a long output
// stall that backs the block up into its input.
// ----------------------------------------------------------------------------
module bitsliced_gate_interpreter_tb import bgi_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 300;
  localparam int RECENT_DEPTH  = 8;

  typedef struct {
    bgi_op_t                     op;
    logic [BGI_ADDR_FIELD_W-1:0] dest;
    logic [BGI_ADDR_FIELD_W-1:0] src_a;
    logic [BGI_ADDR_FIELD_W-1:0] src_b;
    logic [BGI_LANE_W-1:0]       lane;
    logic                        bit_value;
    logic [BGI_WORD_W-1:0]       random_word;
  } gate_item_t;

  typedef struct {
    logic [BGI_WORD_W-1:0] result_word;
    logic                  status;
  } gate_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                     cfg_we;
  logic [BGI_CFG_IDX_W-1:0] cfg_index;
  logic [BGI_LANES_W-1:0]   cfg_data;

  bgi_in_if  in_ch();
  bgi_out_if out_ch();

  bitsliced_gate_interpreter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // shadow state of the block
  logic [BGI_WORD_W-1:0]  word_mem_model [BGI_MEM_WORDS];
  bit                     word_known     [BGI_MEM_WORDS];
  int                     known_addrs[$];
  int                     recent_addrs[$];
  logic [BGI_LANES_W-1:0] lanes_cfg   = 7'd64;
  logic                   rand_en_cfg = 1'b1;

  gate_result_t pending_results[$];
  int           failures = 0;
  int           src_idle_pct = 0;
  int           sink_idle_pct = 0;
  int           hold_ticket = 0;

  // bits of lanes 0 .. count-1, lane j at word bit j ^ 7
  function automatic logic [BGI_WORD_W-1:0] active_lane_mask(
    input logic [BGI_LANES_W-1:0] count
  );
    logic [BGI_WORD_W-1:0] m;
    int j;
    m = '0;
    for (j = 0; j < BGI_WORD_W; j++)
      if (j < count) m[j ^ 7] = 1'b1;
    return m;
  endfunction

  // evaluate one gate against the shadow memory and commit its write
  function automatic gate_result_t apply_gate(input gate_item_t g);
    gate_result_t r;
    int d, a, b, pos;
    logic wr;
    d = int'(g.dest) % BGI_MEM_WORDS;
    a = int'(g.src_a) % BGI_MEM_WORDS;
    b = int'(g.src_b) % BGI_MEM_WORDS;
    pos = int'(g.lane ^ BGI_LANE_SWAP);
    r.result_word = '0;
    r.status = 1'b0;
    wr = 1'b1;
    case (g.op)
      OP_XOR:    r.result_word = word_mem_model[a] ^ word_mem_model[b];
      OP_AND:    r.result_word = word_mem_model[a] & word_mem_model[b];
      OP_OR:     r.result_word = word_mem_model[a] | word_mem_model[b];
      OP_NOT:    r.result_word = active_lane_mask(lanes_cfg) ^ word_mem_model[a];
      OP_RANDOM: r.result_word = rand_en_cfg ? g.random_word : '0;
      OP_LOAD: begin
        // lane 0 starts a fresh word, other lanes only OR in
        r.result_word = (g.lane == '0) ? '0 : word_mem_model[d];
        r.result_word[pos] = r.result_word[pos] | g.bit_value;
      end
      OP_READ: begin
        r.result_word[0] = word_mem_model[a][pos];
        wr = 1'b0;
      end
      default: begin
        r.status = 1'b1;
        wr = 1'b0;
      end
    endcase
    if (wr) begin
      word_mem_model[d] = r.result_word;
      if (!word_known[d]) begin
        word_known[d] = 1'b1;
        known_addrs.push_back(d);
      end
      recent_addrs.push_back(d);
      if (recent_addrs.size() > RECENT_DEPTH) void'(recent_addrs.pop_front());
    end
    return r;
  endfunction

  function automatic gate_item_t make_gate(input bgi_op_t op, input int dest, input int src_a,
                                           input int src_b, input int lane,
                                           input logic bit_value,
                                           input logic [BGI_WORD_W-1:0] random_word);
    gate_item_t g;
    g.op = op;
    g.dest = BGI_ADDR_FIELD_W'(dest);
    g.src_a = BGI_ADDR_FIELD_W'(src_a);
    g.src_b = BGI_ADDR_FIELD_W'(src_b);
    g.lane = BGI_LANE_W'(lane);
    g.bit_value = bit_value;
    g.random_word = random_word;
    return g;
  endfunction

  // a written address, biased toward the last few writes to hit read-after-write
  function automatic int known_addr();
    if (recent_addrs.size() != 0 && $urandom_range(99) < 60)
      return recent_addrs[$urandom_range(recent_addrs.size() - 1)];
    return known_addrs[$urandom_range(known_addrs.size() - 1)];
  endfunction

  function automatic gate_item_t random_gate();
    gate_item_t g;
    int pick;
    pick = $urandom_range(99);
    if (pick < 14)      g.op = OP_XOR;
    else if (pick < 28) g.op = OP_AND;
    else if (pick < 42) g.op = OP_OR;
    else if (pick < 52) g.op = OP_NOT;
    else if (pick < 63) g.op = OP_RANDOM;
    else if (pick < 80) g.op = OP_LOAD;
    else if (pick < 95) g.op = OP_READ;
    else                g.op = OP_INVALID;
    g.lane = BGI_LANE_W'($urandom_range(63));
    if (g.op == OP_LOAD && $urandom_range(99) < 25) g.lane = '0;
    g.bit_value = 1'($urandom_range(1));
    pick = $urandom_range(9);
    if (pick == 0)      g.random_word = '0;
    else if (pick == 1) g.random_word = '1;
    else                g.random_word = {$urandom, $urandom};
    g.src_a = BGI_ADDR_FIELD_W'(known_addr());
    g.src_b = BGI_ADDR_FIELD_W'(known_addr());
    // OR-ing a bit load reads its destination, so that word must exist
    if ((g.op == OP_LOAD && g.lane != '0) || $urandom_range(1) == 1)
      g.dest = BGI_ADDR_FIELD_W'(known_addr());
    else g.dest = BGI_ADDR_FIELD_W'($urandom_range(BGI_MEM_WORDS - 1));
    return g;
  endfunction

  // send one item; returns in the time step of the accepting edge
  task automatic send_gate(input gate_item_t g);
    @(negedge clk);
    if ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < src_idle_pct) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.operation    <= g.op;
    in_ch.dest_address <= g.dest;
    in_ch.source_a     <= g.src_a;
    in_ch.source_b     <= g.src_b;
    in_ch.lane         <= g.lane;
    in_ch.bit_value    <= g.bit_value;
    in_ch.random_word  <= g.random_word;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.push_back(apply_gate(g));
  endtask

  // stop sending and let every outstanding result come back
  task automatic wait_for_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input bgi_cfg_idx_t idx, input logic [BGI_LANES_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    if (idx == CFG_BATCH_LANES) lanes_cfg = value;
    else rand_en_cfg = value[0];
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_random_enable(input logic en);
    write_register(CFG_RANDOM_ENABLE, {6'($urandom_range(63)), en});
  endtask

  // corner cases of every operation with the reset configuration
  task automatic test_directed_gates();
    src_idle_pct = 0;
    sink_idle_pct = 0;
    send_gate(make_gate(OP_RANDOM, 0, 0, 0, 0, 1'b0, '1));
    send_gate(make_gate(OP_RANDOM, 4095, 0, 0, 63, 1'b1, 64'h5555_5555_5555_5555));
    send_gate(make_gate(OP_RANDOM, 'hAAA, 0, 4095, 0, 1'b0, 64'h0123_4567_89AB_CDEF));
    send_gate(make_gate(OP_XOR, 1, 0, 4095, 0, 1'b0, '0));
    send_gate(make_gate(OP_AND, 2, 0, 4095, 0, 1'b0, '0));
    send_gate(make_gate(OP_OR, 3, 'hAAA, 4095, 0, 1'b0, '0));
    send_gate(make_gate(OP_NOT, 4, 4095, 0, 0, 1'b0, '0));
    // bit loads: lane 0 clears, others only set
    send_gate(make_gate(OP_LOAD, 5, 0, 0, 0, 1'b1, '0));
    send_gate(make_gate(OP_LOAD, 5, 0, 0, 63, 1'b1, '0));
    send_gate(make_gate(OP_LOAD, 5, 0, 0, 9, 1'b0, '0));
    send_gate(make_gate(OP_LOAD, 0, 0, 0, 0, 1'b0, '0));
    send_gate(make_gate(OP_READ, 0, 5, 0, 0, 1'b0, '0));
    send_gate(make_gate(OP_READ, 0, 5, 0, 63, 1'b0, '0));
    send_gate(make_gate(OP_READ, 4095, 4095, 4095, 7, 1'b0, '0));
    // back-to-back dependencies through the write path
    send_gate(make_gate(OP_XOR, 6, 5, 5, 0, 1'b0, '0));
    send_gate(make_gate(OP_AND, 7, 6, 1, 0, 1'b0, '0));
    send_gate(make_gate(OP_OR, 7, 7, 3, 0, 1'b0, '0));
    send_gate(make_gate(OP_NOT, 7, 7, 7, 0, 1'b0, '0));
    send_gate(make_gate(OP_INVALID, 'h800, 1, 2, 'h2A, 1'b1, {$urandom, $urandom}));
    send_gate(make_gate(OP_LOAD, 4095, 3, 4, 5, 1'b1, '0));
    send_gate(make_gate(OP_READ, 'h555, 4095, 2, 5, 1'b1, '1));
    wait_for_results();
  endtask

  // NOT mask at lane-count extremes, RANDOM with randomness off and on
  task automatic test_lane_config();
    logic [BGI_LANES_W-1:0] counts [5] = '{7'd0, 7'd1, 7'd64, 7'd65, 7'd127};
    foreach (counts[i]) begin
      write_register(CFG_BATCH_LANES, counts[i]);
      // word 0 holds zero here, so NOT returns the mask itself
      send_gate(make_gate(OP_NOT, 'h100, 0, 0, 0, 1'b0, '0));
      wait_for_results();
    end
    write_random_enable(1'b0);
    send_gate(make_gate(OP_RANDOM, 'h200, 0, 0, 0, 1'b0, '1));
    send_gate(make_gate(OP_RANDOM, 'h201, 0, 0, 0, 1'b0, {$urandom, $urandom}));
    wait_for_results();
    write_random_enable(1'b1);
    send_gate(make_gate(OP_RANDOM, 'h202, 0, 0, 0, 1'b0, '1));
    wait_for_results();
  endtask

  // random gates in chunks, each with a fresh configuration
  task automatic test_random_traffic(input int chunks, input int per_chunk, input int src_pct,
                                     input int sink_pct);
    int pick;
    src_idle_pct = src_pct;
    sink_idle_pct = sink_pct;
    repeat (chunks) begin
      pick = $urandom_range(9);
      if (pick < 3) write_register(CFG_BATCH_LANES, ($urandom_range(1)) ? 7'd127 : 7'd0);
      else write_register(CFG_BATCH_LANES, BGI_LANES_W'($urandom_range(1, 64)));
      write_random_enable($urandom_range(99) < 75);
      repeat (per_chunk) send_gate(random_gate());
      wait_for_results();
    end
  endtask

  // long receiver stall while items keep coming
  task automatic test_output_backpressure();
    src_idle_pct = 0;
    sink_idle_pct = 0;
    hold_ticket++;
    repeat (40) send_gate(random_gate());
    wait_for_results();
  endtask

  // result receiver: random stalls plus an occasional long hold
  initial begin
    int hold_left;
    int tickets_seen;
    hold_left = 0;
    tickets_seen = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_ticket != tickets_seen) begin
        tickets_seen = hold_ticket;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    gate_result_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result item with no expected result: word %h status %b",
               out_ch.result_word, out_ch.status);
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.result_word !== want.result_word) begin
          $error("result_word mismatch: expected %h, got %h",
                 want.result_word, out_ch.result_word);
          failures++;
        end
        if (out_ch.status !== want.status) begin
          $error("status mismatch: expected %b, got %b", want.status, out_ch.status);
          failures++;
        end
      end
    end
  end

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_BATCH_LANES;
    cfg_data           = '0;
    in_ch.valid        = 1'b0;
    in_ch.operation    = OP_XOR;
    in_ch.dest_address = '0;
    in_ch.source_a     = '0;
    in_ch.source_b     = '0;
    in_ch.lane         = '0;
    in_ch.bit_value    = 1'b0;
    in_ch.random_word  = '0;
    foreach (word_known[i]) word_known[i] = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_gates();
    test_lane_config();
    test_random_traffic(3, 165, 27, 57);
    test_random_traffic(3, 165, 57, 27);
    test_random_traffic(3, 165, 0, 0);
    test_output_backpressure();

    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // run limit
  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
